// ----- src/fdc_pkg.sv -----
// Shared constants, types and tables of the CRC-32C checked frame deframer.
package fdc_pkg;

   localparam int unsigned HEADER_BYTES = 12;
   localparam int unsigned CRC_BYTES    = 4;
   localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);
   localparam int unsigned PLEN_IDX     = 9;

   localparam int unsigned POS_W  = 9;
   localparam int unsigned FLEN_W = POS_W + 1;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_NIB [16] = '{
      32'h0000_0000, 32'h105E_C76F, 32'h20BD_8EDE, 32'h30E3_49B1,
      32'h417B_1DBC, 32'h5125_DAD3, 32'h61C6_9362, 32'h7198_540D,
      32'h82F6_3B78, 32'h92A8_FC17, 32'hA24B_B5A6, 32'hB215_72C9,
      32'hC38D_26C4, 32'hD3D3_E1AB, 32'hE330_A81A, 32'hF36E_6F75};

   localparam logic [3:0] MAGIC_NIBBLE = 4'hA;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FORMAT  = 2'd1;
   localparam logic [1:0] STAT_VERSION = 2'd2;
   localparam logic [1:0] STAT_CRC     = 2'd3;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] REG_PROTOCOL_VERSION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PROFILE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_CLASS        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_FRAGMENTS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_FRAME_BYTES  = 3'd4;

   typedef struct packed {
      logic [3:0]  protocol_version;
      logic [3:0]  max_profile;
      logic [3:0]  max_class;
      logic [7:0]  max_fragments;
      logic [8:0]  max_frame_bytes;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      protocol_version: 4'd1,
      max_profile:      4'd15,
      max_class:        4'd15,
      max_fragments:    8'd255,
      max_frame_bytes:  9'd271};

   typedef struct packed {
      logic [3:0]  profile;
      logic [3:0]  flags;
      logic [15:0] flow_num;
      logic [15:0] sequence_res;
      logic [7:0]  frag_index;
      logic [7:0]  frag_total;
      logic [3:0]  traffic_class;
      logic [3:0]  priority_res;
      logic [15:0] link_tag;
   } hdr_fields_type;

   typedef struct packed {
      logic           kind;
      logic [7:0]     data_byte;
      logic [1:0]     status;
      hdr_fields_type fields;
   } rsp_item_type;

endpackage

// ----- src/fdc_ifs.sv -----
// Valid/ready channel interfaces for the request, result and register write ports.
interface fdc_req_if import fdc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] wire_byte;
   logic       last_byte;

   modport source (output valid, output wire_byte, output last_byte, input ready);
   modport sink (input valid, input wire_byte, input last_byte, output ready);
endinterface

interface fdc_rsp_if import fdc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_byte;
   logic [1:0]  status;
   logic [3:0]  profile;
   logic [3:0]  flags;
   logic [15:0] flow_num;
   logic [15:0] sequence_res;
   logic [7:0]  frag_index;
   logic [7:0]  frag_total;
   logic [3:0]  traffic_class;
   logic [3:0]  priority_res;
   logic [15:0] link_tag;

   modport source (output valid, output kind, output data_byte, output status,
                   output profile, output flags, output flow_num, output sequence_res,
                   output frag_index, output frag_total, output traffic_class,
                   output priority_res, output link_tag, input ready);
   modport sink (input valid, input kind, input data_byte, input status,
                 input profile, input flags, input flow_num, input sequence_res,
                 input frag_index, input frag_total, input traffic_class,
                 input priority_res, input link_tag, output ready);
endinterface

interface fdc_csr_if import fdc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/fdc_hdr.sv -----
// Byte position counter and header byte store with field decode.
module fdc_hdr import fdc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             last,
   input  logic [7:0]       wire_byte,
   output logic [POS_W-1:0] pos,
   output logic [7:0]       plen,
   output logic [7:0]       h0,
   output hdr_fields_type   fields
);

   localparam logic [POS_W-1:0] HDR_END = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] PLEN_POS = POS_W'(PLEN_IDX);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       hdr_ff [HEADER_BYTES];

   always_comb begin
      pos_in = pos_ff;
      if (step) begin
         if (last) begin
            pos_in = '0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && (pos_ff < HDR_END)) begin
         hdr_ff[pos_ff[HDR_IDX_W-1:0]] <= wire_byte;
      end
   end

   // The length byte is in use from the cycle it arrives.
   assign plen = (pos_ff == PLEN_POS) ? wire_byte : hdr_ff[PLEN_IDX];
   assign pos  = pos_ff;
   assign h0   = hdr_ff[0];

   assign fields.profile       = hdr_ff[1][3:0];
   assign fields.flags         = hdr_ff[1][7:4];
   assign fields.flow_num      = {hdr_ff[2], hdr_ff[3]};
   assign fields.sequence_res  = {hdr_ff[4], hdr_ff[5]};
   assign fields.frag_index    = hdr_ff[6];
   assign fields.frag_total    = hdr_ff[7];
   assign fields.traffic_class = hdr_ff[8][7:4];
   assign fields.priority_res  = hdr_ff[8][3:0];
   assign fields.link_tag      = {hdr_ff[10], hdr_ff[11]};

   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      step && last |=> pos_ff == '0)
      else $error("byte position not cleared after the final byte");

   a_pos_saturate: assert property (@(posedge clock) disable iff (reset)
      step && !last && pos_ff == POS_MAX |=> pos_ff == POS_MAX)
      else $error("byte position wrapped instead of saturating");

endmodule

// ----- src/fdc_crc.sv -----
// Running CRC-32C over header and payload, and the trailing received CRC.
module fdc_crc import fdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       last,
   input  logic       in_body,
   input  logic [7:0] wire_byte,
   output logic       crc_match
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] rcv_ff, rcv_in;
   logic [31:0] crc_next, rcv_next;

   // Reflected CRC-32C, two nibble lookups per byte.
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'd0, b};
      x = {4'd0, x[31:4]} ^ CRC_NIB[x[3:0]];
      x = {4'd0, x[31:4]} ^ CRC_NIB[x[3:0]];
      return x;
   endfunction

   assign crc_next  = in_body ? crc_byte(crc_ff, wire_byte) : crc_ff;
   assign rcv_next  = {rcv_ff[23:0], wire_byte};
   assign crc_match = (~crc_next) == rcv_next;

   always_comb begin
      crc_in = crc_ff;
      rcv_in = rcv_ff;
      if (step) begin
         if (last) begin
            crc_in = CRC_INIT;
            rcv_in = '0;
         end else begin
            crc_in = crc_next;
            rcv_in = rcv_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
         rcv_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         rcv_ff <= rcv_in;
      end
   end

   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      step && last |=> crc_ff == CRC_INIT && rcv_ff == '0)
      else $error("CRC state not restored after the final byte");

   a_crc_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(crc_ff) && $stable(rcv_ff))
      else $error("CRC state changed without an accepted item");

   a_crc_skip: assert property (@(posedge clock) disable iff (reset)
      step && !last && !in_body |=> $stable(crc_ff))
      else $error("CRC advanced on a byte outside the covered range");

endmodule

// ----- src/fdc_chk.sv -----
// End-of-frame status decision in priority order.
module fdc_chk import fdc_pkg::*; (
   input  logic [POS_W-1:0] pos,
   input  logic [7:0]       plen,
   input  logic [7:0]       h0,
   input  logic             crc_match,
   input  hdr_fields_type   fields,
   input  cfg_type          cfg,
   output logic [1:0]       status,
   output logic             decode
);

   localparam logic [FLEN_W-1:0] MIN_FRAME = FLEN_W'(HEADER_BYTES + CRC_BYTES);

   logic [FLEN_W-1:0] flen;
   logic [FLEN_W-1:0] expected_len;
   logic              range_bad;

   assign flen         = FLEN_W'(pos) + 1'b1;
   assign expected_len = MIN_FRAME + FLEN_W'(plen);

   assign range_bad = (fields.profile > cfg.max_profile)
                   || (fields.traffic_class > cfg.max_class)
                   || (fields.frag_total == 8'd0)
                   || (fields.frag_total > cfg.max_fragments)
                   || (fields.frag_index >= fields.frag_total);

   always_comb begin
      status = STAT_OK;
      decode = 1'b0;
      if ((flen < MIN_FRAME) || (flen > FLEN_W'(cfg.max_frame_bytes))) begin
         status = STAT_FORMAT;
      end else if (h0 != {MAGIC_NIBBLE, cfg.protocol_version}) begin
         status = (h0[7:4] == MAGIC_NIBBLE) ? STAT_VERSION : STAT_FORMAT;
      end else if (flen != expected_len) begin
         status = STAT_FORMAT;
      end else if (!crc_match) begin
         status = STAT_CRC;
      end else begin
         decode = 1'b1;
         if (range_bad) begin
            status = STAT_FORMAT;
         end
      end
   end

endmodule

// ----- src/frame_deframer_crc32c_check.sv -----
// Top level of the CRC-32C checked frame deframer.
//
// A received frame enters on req_chan one byte per item, wire_byte in wire
// order, with last_byte set on the final byte. The first twelve bytes are the
// big-endian header, header byte 9 gives the payload length, and the frame
// ends in a four-byte big-endian CRC-32C over header and payload.
// Payload bytes leave on rsp_chan as kind 0 items as they arrive. The final
// byte produces one kind 1 status item carrying the decoded header fields;
// those fields are zero on length, version and CRC errors. Any nonzero status
// tells the receiver to drop the payload it has already seen.
// An item accepted at one edge shows its result, if it has one, on rsp_chan
// right after that edge. One item is accepted every cycle unless the
// receiver stalls; the CRC update of two nibble lookups and the header checks
// fit between the input handshake and the single output register.
// When the receiver stalls, the output register holds its item and req_chan
// ready drops until that item is taken; it returns in the same cycle the
// receiver takes it. csr_chan is always ready and writes are meant for idle
// periods only. Reset clears the position counter, the CRC state, the output
// valid and the registers to their defaults; no clearing pass is needed.
module frame_deframer_crc32c_check import fdc_pkg::*; (
   input logic   clock,
   input logic   reset,
   fdc_req_if.sink   req_chan,
   fdc_rsp_if.source rsp_chan,
   fdc_csr_if.sink   csr_chan
);

   localparam logic [POS_W-1:0] HDR_END = POS_W'(HEADER_BYTES);

   cfg_type          cfg_ff, cfg_in;
   rsp_item_type     rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             step;
   logic             last;
   logic [POS_W-1:0] pos;
   logic [7:0]       plen;
   logic [7:0]       h0;
   hdr_fields_type   fields;
   logic             in_body;
   logic             payload;
   logic             crc_match;
   logic [1:0]       status;
   logic             decode;

   // Register writes never stall.
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_PROTOCOL_VERSION: cfg_in.protocol_version = csr_chan.data[3:0];
            REG_MAX_PROFILE:      cfg_in.max_profile      = csr_chan.data[3:0];
            REG_MAX_CLASS:        cfg_in.max_class        = csr_chan.data[3:0];
            REG_MAX_FRAGMENTS:    cfg_in.max_fragments    = csr_chan.data[7:0];
            REG_MAX_FRAME_BYTES:  cfg_in.max_frame_bytes  = csr_chan.data[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The output register frees up whenever the receiver takes its item.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign step           = req_chan.valid && req_chan.ready;
   assign last           = req_chan.last_byte;

   fdc_hdr u_hdr (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .last      (last),
      .wire_byte (req_chan.wire_byte),
      .pos       (pos),
      .plen      (plen),
      .h0        (h0),
      .fields    (fields)
   );

   // Bytes before the end of the payload are covered by the CRC. Header bytes
   // always are, even before this frame's length byte has arrived.
   assign in_body = (pos < HDR_END) || (pos < (HDR_END + POS_W'(plen)));
   assign payload = (pos >= HDR_END) && in_body && !last;

   fdc_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .last      (last),
      .in_body   (in_body),
      .wire_byte (req_chan.wire_byte),
      .crc_match (crc_match)
   );

   fdc_chk u_chk (
      .pos       (pos),
      .plen      (plen),
      .h0        (h0),
      .crc_match (crc_match),
      .fields    (fields),
      .cfg       (cfg_ff),
      .status    (status),
      .decode    (decode)
   );

   always_comb begin
      rsp_in = '0;
      if (last) begin
         rsp_in.kind   = KIND_STATUS;
         rsp_in.status = status;
         if (decode) begin
            rsp_in.data_byte = plen;
            rsp_in.fields    = fields;
         end
      end else begin
         rsp_in.kind      = KIND_PAYLOAD;
         rsp_in.data_byte = req_chan.wire_byte;
      end
   end

   // An accepted item either loads a new result or leaves the register empty,
   // because acceptance implies the old result has been taken.
   assign rsp_valid_in = step ? (last || payload) : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && (last || payload)) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_ff.kind;
   assign rsp_chan.data_byte     = rsp_ff.data_byte;
   assign rsp_chan.status        = rsp_ff.status;
   assign rsp_chan.profile       = rsp_ff.fields.profile;
   assign rsp_chan.flags         = rsp_ff.fields.flags;
   assign rsp_chan.flow_num      = rsp_ff.fields.flow_num;
   assign rsp_chan.sequence_res  = rsp_ff.fields.sequence_res;
   assign rsp_chan.frag_index    = rsp_ff.fields.frag_index;
   assign rsp_chan.frag_total    = rsp_ff.fields.frag_total;
   assign rsp_chan.traffic_class = rsp_ff.fields.traffic_class;
   assign rsp_chan.priority_res  = rsp_ff.fields.priority_res;
   assign rsp_chan.link_tag      = rsp_ff.fields.link_tag;

   a_final_gives_status: assert property (@(posedge clock) disable iff (reset)
      step && last |=> rsp_valid_ff && rsp_ff.kind == KIND_STATUS)
      else $error("final byte did not produce a status item");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_PAYLOAD |->
         rsp_ff.status == STAT_OK && rsp_ff.fields == '0)
      else $error("payload item carries status or header fields");

   a_early_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_STATUS &&
      (rsp_ff.status == STAT_VERSION || rsp_ff.status == STAT_CRC) |->
         rsp_ff.data_byte == 8'd0 && rsp_ff.fields == '0)
      else $error("early error status carries header fields");

endmodule

// ----- tb/sv/fdc_tb_pkg.sv -----
// Byte-level predictor and result checker for the CRC-32C checked frame deframer bench.
package fdc_tb_pkg;
   import fdc_pkg::*;

   localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;

   // Bitwise reflected CRC-32C update; the block uses nibble tables, this does not.
   function automatic logic [31:0] crc32c_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      int          i;
      c = crc ^ {24'd0, b};
      for (i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
      end
      return c;
   endfunction

   class frame_result_tracker;
      cfg_type      cfg;
      logic [8:0]   position;
      logic [31:0]  crc_acc;
      logic [31:0]  tail_word;
      logic [7:0]   header [HEADER_BYTES];
      rsp_item_type awaited [$];
      int unsigned  mismatches;
      int unsigned  payload_count;
      int unsigned  status_count [4];

      function new();
         cfg = CFG_RESET;
         foreach (header[i]) header[i] = 8'd0;
         foreach (status_count[i]) status_count[i] = 0;
         mismatches = 0;
         payload_count = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         position = '0;
         crc_acc = 32'hFFFF_FFFF;
         tail_word = '0;
      endfunction

      function void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_PROTOCOL_VERSION: cfg.protocol_version = val[3:0];
            REG_MAX_PROFILE:      cfg.max_profile = val[3:0];
            REG_MAX_CLASS:        cfg.max_class = val[3:0];
            REG_MAX_FRAGMENTS:    cfg.max_fragments = val[7:0];
            REG_MAX_FRAME_BYTES:  cfg.max_frame_bytes = val[8:0];
            default: ;
         endcase
      endfunction

      // Takes one accepted byte and queues the result it must cause, if any.
      function void absorb_byte(input logic [7:0] b, input logic last);
         int unsigned  pos;
         int unsigned  body_end;
         int unsigned  flen;
         logic [7:0]   fidx;
         logic [7:0]   fcnt;
         logic [1:0]   st;
         logic         decode;
         rsp_item_type want;
         pos = position;
         if (pos < HEADER_BYTES) header[pos] = b;
         body_end = HEADER_BYTES + header[PLEN_IDX];
         if (pos < body_end) crc_acc = crc32c_step(crc_acc, b);
         tail_word = {tail_word[23:0], b};
         if (position != POS_MAX) position = position + 1'b1;
         want = '0;
         if (!last) begin
            if (pos >= HEADER_BYTES && pos < body_end) begin
               want.kind = KIND_PAYLOAD;
               want.data_byte = b;
               awaited.push_back(want);
            end
            return;
         end
         flen = pos + 1;
         fidx = header[6];
         fcnt = header[7];
         st = STAT_OK;
         decode = 1'b0;
         if (flen < HEADER_BYTES + CRC_BYTES || flen > cfg.max_frame_bytes) begin
            st = STAT_FORMAT;
         end else if (header[0] != {MAGIC_NIBBLE, cfg.protocol_version}) begin
            st = (header[0][7:4] == MAGIC_NIBBLE) ? STAT_VERSION : STAT_FORMAT;
         end else if (flen != body_end + CRC_BYTES) begin
            st = STAT_FORMAT;
         end else if (~crc_acc != tail_word) begin
            st = STAT_CRC;
         end else begin
            decode = 1'b1;
            if (header[1][3:0] > cfg.max_profile || header[8][7:4] > cfg.max_class ||
                fcnt == 8'd0 || fcnt > cfg.max_fragments || fidx >= fcnt)
               st = STAT_FORMAT;
         end
         want.kind = KIND_STATUS;
         want.status = st;
         if (decode) begin
            want.data_byte = header[PLEN_IDX];
            want.fields.profile = header[1][3:0];
            want.fields.flags = header[1][7:4];
            want.fields.flow_num = {header[2], header[3]};
            want.fields.sequence_res = {header[4], header[5]};
            want.fields.frag_index = fidx;
            want.fields.frag_total = fcnt;
            want.fields.traffic_class = header[8][7:4];
            want.fields.priority_res = header[8][3:0];
            want.fields.link_tag = {header[10], header[11]};
         end
         awaited.push_back(want);
         restart_frame();
      endfunction

      function void compare_field(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(input rsp_item_type got);
         rsp_item_type want;
         if (awaited.size() == 0) begin
            $error("result with nothing awaited: kind %0d data_byte 0x%02h status %0d",
                   got.kind, got.data_byte, got.status);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("data_byte", want.data_byte, got.data_byte);
         compare_field("status", want.status, got.status);
         compare_field("profile", want.fields.profile, got.fields.profile);
         compare_field("flags", want.fields.flags, got.fields.flags);
         compare_field("flow_num", want.fields.flow_num, got.fields.flow_num);
         compare_field("sequence_res", want.fields.sequence_res, got.fields.sequence_res);
         compare_field("frag_index", want.fields.frag_index, got.fields.frag_index);
         compare_field("frag_total", want.fields.frag_total, got.fields.frag_total);
         compare_field("traffic_class", want.fields.traffic_class,
                       got.fields.traffic_class);
         compare_field("priority_res", want.fields.priority_res, got.fields.priority_res);
         compare_field("link_tag", want.fields.link_tag, got.fields.link_tag);
         if (want.kind == KIND_PAYLOAD) payload_count++;
         else status_count[want.status]++;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction
   endclass

endpackage

// ----- tb/sv/frame_deframer_crc32c_check_tb.sv -----
// Top-level bench of the CRC-32C checked frame deframer: stimulus, stalls and checking.
module frame_deframer_crc32c_check_tb;
   import fdc_pkg::*;
   import fdc_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Register indexes beyond the last defined one; writes there must be ignored.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned HOLD_CYCLES   = 80;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned PHASE_BYTES   = 150;

   // Shapes of generated frames. Most are well formed so that the CRC and field
   // range checks are reached; the rest break one rule each or are plain noise.
   typedef enum int {
      SHAPE_GOOD,
      SHAPE_BAD_CRC,
      SHAPE_BAD_VERSION,
      SHAPE_BAD_MAGIC,
      SHAPE_CUT_SHORT,
      SHAPE_RUN_LONG,
      SHAPE_TINY,
      SHAPE_NOISE,
      SHAPE_OVERSIZE
   } frame_shape_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fdc_req_if req_chan ();
   fdc_rsp_if rsp_chan ();
   fdc_csr_if csr_chan ();

   frame_deframer_crc32c_check dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   frame_result_tracker tracker;
   logic [7:0]          frame_buf [$];
   rsp_item_type        seen;
   bit                  no_idle = 1'b0;
   bit                  hold_request = 1'b0;
   int unsigned         cycle_count = 0;
   int unsigned         frames_sent = 0;
   int unsigned         bytes_sent = 0;
   int unsigned         settings_used = 1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog. The slowest correct run is far below this limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Gap lengths for both sides: mostly none or short, now and then long. While
   // no_idle is set neither side takes a random gap.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // Everything happens at the rising edge, on values that were driven at the
   // falling edge, so the order of processes within a time step does not matter.
   // Register writes update the predictor's copy of the configuration here too.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready)
            tracker.apply_register(csr_chan.index, csr_chan.data);
         if (req_chan.valid && req_chan.ready)
            tracker.absorb_byte(req_chan.wire_byte, req_chan.last_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.kind = rsp_chan.kind;
            seen.data_byte = rsp_chan.data_byte;
            seen.status = rsp_chan.status;
            seen.fields.profile = rsp_chan.profile;
            seen.fields.flags = rsp_chan.flags;
            seen.fields.flow_num = rsp_chan.flow_num;
            seen.fields.sequence_res = rsp_chan.sequence_res;
            seen.fields.frag_index = rsp_chan.frag_index;
            seen.fields.frag_total = rsp_chan.frag_total;
            seen.fields.traffic_class = rsp_chan.traffic_class;
            seen.fields.priority_res = rsp_chan.priority_res;
            seen.fields.link_tag = rsp_chan.link_tag;
            tracker.check_result(seen);
         end
      end
   end

   // Receiver. It stalls at random, and when the stimulus asks for it, it holds
   // ready low for a long stretch of its own so the output register fills and
   // the block has to push back on its input while the sender keeps offering.
   initial begin : receiver
      int unsigned n;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            n = pick_gap();
            if (n == 0) begin
               rsp_chan.ready = 1'b1;
            end else begin
               rsp_chan.ready = 1'b0;
               repeat (n - 1) @(negedge clock);
            end
         end
      end
   end

   // Offers one byte after a random gap and returns at the falling edge after it
   // was taken. Valid stays high into the next item unless that item waits.
   task automatic send_item(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.wire_byte = b;
      req_chan.last_byte = last;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) send_item(frame_buf[i], i == frame_buf.size() - 1);
      frames_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data = val;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] version,
                            input logic [CSR_DATA_W-1:0] profile_max,
                            input logic [CSR_DATA_W-1:0] class_max,
                            input logic [CSR_DATA_W-1:0] fragments_max,
                            input logic [CSR_DATA_W-1:0] frame_max);
      write_reg(REG_PROTOCOL_VERSION, version);
      write_reg(REG_MAX_PROFILE, profile_max);
      write_reg(REG_MAX_CLASS, class_max);
      write_reg(REG_MAX_FRAGMENTS, fragments_max);
      write_reg(REG_MAX_FRAME_BYTES, frame_max);
      settings_used++;
   endtask

   // The sender stops until every awaited result has come back, then idles
   // with valid low before it returns. Register writes only happen after this.
   task automatic settle();
      req_chan.valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Appends the big-endian CRC-32C of everything in the buffer so far.
   task automatic append_crc();
      logic [31:0] c;
      c = 32'hFFFF_FFFF;
      foreach (frame_buf[i]) c = crc32c_step(c, frame_buf[i]);
      c = ~c;
      frame_buf.push_back(c[31:24]);
      frame_buf.push_back(c[23:16]);
      frame_buf.push_back(c[15:8]);
      frame_buf.push_back(c[7:0]);
   endtask

   // Header nibbles mostly inside the configured limit so that good frames pass.
   function automatic logic [3:0] pick_nibble(input logic [3:0] limit);
      if ($urandom_range(0, 99) < 85) return 4'($urandom_range(0, limit));
      return 4'($urandom);
   endfunction

   // Payload lengths stay small most of the time, with a few near the maximum.
   // Usually they are also cut to what the frame length limit lets through.
   function automatic logic [7:0] pick_payload_len();
      int unsigned r;
      int unsigned len;
      int unsigned room;
      r = $urandom_range(0, 99);
      if (r < 75) len = $urandom_range(0, 12);
      else if (r < 93) len = $urandom_range(13, 64);
      else len = $urandom_range(200, 255);
      room = tracker.cfg.max_frame_bytes - (HEADER_BYTES + CRC_BYTES);
      if ($urandom_range(0, 9) != 0 && len > room) len = room;
      return 8'(len);
   endfunction

   function automatic frame_shape_type pick_shape();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return SHAPE_GOOD;
      if (r < 63) return SHAPE_BAD_CRC;
      if (r < 69) return SHAPE_BAD_VERSION;
      if (r < 73) return SHAPE_BAD_MAGIC;
      if (r < 80) return SHAPE_CUT_SHORT;
      if (r < 86) return SHAPE_RUN_LONG;
      if (r < 93) return SHAPE_TINY;
      return SHAPE_NOISE;
   endfunction

   task automatic build_frame(input frame_shape_type shape);
      logic [7:0]  plen;
      logic [7:0]  fcnt;
      int unsigned n;
      int unsigned idx;
      frame_buf.delete();
      // Unstructured frames: too short for a frame, random bytes, or long
      // enough to drive the byte counter into saturation.
      if (shape == SHAPE_TINY || shape == SHAPE_NOISE || shape == SHAPE_OVERSIZE) begin
         if (shape == SHAPE_TINY) n = $urandom_range(1, 15);
         else if (shape == SHAPE_OVERSIZE) n = $urandom_range(512, 530);
         else n = $urandom_range(16, 48);
         repeat (n) frame_buf.push_back(8'($urandom));
         if ($urandom_range(0, 1) != 0)
            frame_buf[0] = {MAGIC_NIBBLE, tracker.cfg.protocol_version};
         return;
      end
      plen = pick_payload_len();
      if ($urandom_range(0, 9) != 0) fcnt = 8'($urandom_range(1, tracker.cfg.max_fragments));
      else fcnt = 8'($urandom);
      frame_buf.push_back({MAGIC_NIBBLE, tracker.cfg.protocol_version});
      frame_buf.push_back({4'($urandom), pick_nibble(tracker.cfg.max_profile)});
      repeat (4) frame_buf.push_back(8'($urandom));
      if ($urandom_range(0, 9) != 0 && fcnt != 8'd0)
         frame_buf.push_back(8'($urandom_range(0, fcnt - 1)));
      else
         frame_buf.push_back(8'($urandom));
      frame_buf.push_back(fcnt);
      frame_buf.push_back({pick_nibble(tracker.cfg.max_class), 4'($urandom)});
      frame_buf.push_back(plen);
      repeat (2) frame_buf.push_back(8'($urandom));
      repeat (plen) frame_buf.push_back(8'($urandom));
      // A wrong version nibble under the right magic nibble is a version error;
      // a wrong magic nibble is a format error.
      if (shape == SHAPE_BAD_VERSION)
         frame_buf[0] = {MAGIC_NIBBLE,
                         tracker.cfg.protocol_version ^ 4'($urandom_range(1, 15))};
      if (shape == SHAPE_BAD_MAGIC)
         frame_buf[0] = {MAGIC_NIBBLE ^ 4'($urandom_range(1, 15)), 4'($urandom)};
      append_crc();
      case (shape)
         SHAPE_BAD_CRC: begin
            // Any byte after the length byte, the CRC itself included.
            idx = $urandom_range(PLEN_IDX + 1, frame_buf.size() - 1);
            frame_buf[idx] = frame_buf[idx] ^ 8'(1 << $urandom_range(0, 7));
         end
         SHAPE_CUT_SHORT: repeat ($urandom_range(1, 4)) void'(frame_buf.pop_back());
         SHAPE_RUN_LONG: repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom));
         default: ;
      endcase
   endtask

   task automatic run_random_frames(input int unsigned budget);
      int unsigned sent;
      sent = 0;
      while (sent < budget) begin
         build_frame(pick_shape());
         sent += frame_buf.size();
         send_frame();
      end
   endtask

   initial begin : stimulus
      tracker = new();
      req_chan.valid = 1'b0;
      req_chan.wire_byte = 8'd0;
      req_chan.last_byte = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed frames at the reset settings. The first frame after reset is a
      // full one so that no header byte is ever used before it was written. It
      // carries extreme header values and an empty payload and must pass. Then
      // a frame of one byte, and one of three all-ones bytes, both too short.
      frame_buf = '{{MAGIC_NIBBLE, CFG_RESET.protocol_version}, 8'hFF, 8'hFF, 8'hFF,
                    8'h00, 8'h00, 8'hFE, 8'hFF, 8'hF0, 8'h00, 8'hFF, 8'hFF};
      append_crc();
      send_frame();
      frame_buf = '{8'h00};
      send_frame();
      frame_buf = '{8'hFF, 8'hFF, 8'hFF};
      send_frame();
      settle();

      // Reset settings. The receiver starts with a long hold while the sender
      // offers back-to-back items, so the block has to stall its input.
      hold_request = 1'b1;
      no_idle = 1'b1;
      build_frame(SHAPE_GOOD);
      send_frame();
      build_frame(SHAPE_GOOD);
      send_frame();
      no_idle = 1'b0;
      run_random_frames(PHASE_BYTES);
      settle();

      // Lowest limits; writes to the spare indexes must change nothing.
      configure(9'd0, 9'd0, 9'd0, 9'd1, 9'd16);
      write_reg(REG_SPARE_LO, 9'($urandom));
      write_reg(REG_SPARE_HI, 9'($urandom));
      run_random_frames(PHASE_BYTES);
      settle();

      // Highest limits, no idling on either side, and one frame long enough to
      // saturate the byte counter.
      configure(9'd15, 9'd15, 9'd15, 9'd255, 9'd271);
      no_idle = 1'b1;
      build_frame(SHAPE_OVERSIZE);
      send_frame();
      run_random_frames(PHASE_BYTES / 4);
      no_idle = 1'b0;
      settle();

      // Random settings. Upper data bits above a field's width are random too
      // and must be dropped.
      configure(9'($urandom), 9'($urandom), 9'($urandom),
                {1'($urandom), 8'($urandom_range(1, 255))}, 9'($urandom_range(16, 60)));
      run_random_frames(PHASE_BYTES);
      settle();
      configure(9'($urandom), 9'($urandom), 9'($urandom),
                {1'($urandom), 8'($urandom_range(1, 255))}, 9'($urandom_range(16, 271)));
      run_random_frames(PHASE_BYTES);
      settle();

      if (tracker.pending() != 0)
         $error("%0d awaited results never arrived", tracker.pending());
      $display("Run covered %0d frames (%0d bytes) under %0d register settings.",
               frames_sent, bytes_sent, settings_used);
      $display("Results: %0d payload, status ok %0d, format %0d, version %0d, crc %0d.",
               tracker.payload_count, tracker.status_count[STAT_OK],
               tracker.status_count[STAT_FORMAT], tracker.status_count[STAT_VERSION],
               tracker.status_count[STAT_CRC]);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/fdc_pkg.sv
src/fdc_ifs.sv
src/fdc_hdr.sv
src/fdc_crc.sv
src/fdc_chk.sv
src/frame_deframer_crc32c_check.sv
tb/sv/fdc_tb_pkg.sv
tb/sv/frame_deframer_crc32c_check_tb.sv
